/* rtl/core/verlet_thermostat_position_step_top_defines.svh */
// Assertion macros for the Verlet position step block.
// Used by the port checker; needs nothing else.
`ifndef VERLET_THERMOSTAT_POSITION_STEP_TOP_DEFINES_SVH
`define VERLET_THERMOSTAT_POSITION_STEP_TOP_DEFINES_SVH

// Same-cycle implication
`define VTPS_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VTPS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vtps_pkg.sv */
// Shared types, codes and helpers for the Verlet position step block.
// No dependencies.
`default_nettype none

package vtps_pkg;

    // Default sizing
    localparam int MAX_ATOMS_DEF = 1024;
    localparam int DRAWS_DEF     = 12;

    // Register indexes
    localparam logic [2:0] CFG_STEP_MODE  = 3'd0;
    localparam logic [2:0] CFG_LAMBDA     = 3'd1;
    localparam logic [2:0] CFG_DT_SQUARED = 3'd2;
    localparam logic [2:0] CFG_LFACTOR    = 3'd3;
    localparam logic [2:0] CFG_HALF_DTG   = 3'd4;
    localparam logic [2:0] CFG_NOISE_AMP  = 3'd5;

    // Register reset values
    localparam logic [31:0] LAMBDA_RST  = 32'h4000_0000;
    localparam logic [31:0] LFACTOR_RST = 32'h8000_0000;

    // Step modes
    localparam logic [1:0] MODE_HOLD     = 2'd0;
    localparam logic [1:0] MODE_SCALED   = 2'd1;
    localparam logic [1:0] MODE_LANGEVIN = 2'd2;

    // Commands
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // 48-bit LCG
    localparam logic [34:0] LCG_MUL = 35'h5_DEEC_E66D;
    localparam logic [47:0] LCG_ADD = 48'hB;

    // Product magnitude cap
    localparam logic [63:0] PROD_CAP = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         atom_index;
        logic [1:0]         axis;
        logic               movable;
        logic signed [47:0] position_now;
        logic signed [47:0] position_before;
        logic signed [47:0] force_in;
        logic [31:0]        inverse_mass;
        logic [31:0]        sqrt_mass;
        logic [47:0]        seed_value;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] new_position;
        logic signed [47:0] force_out;
    } out_item_t;

    // Multiply operations of the step
    typedef enum logic [2:0] {
        OP_AM    = 3'd0,  // noise_amplitude * sqrt_mass
        OP_NOISE = 3'd1,  // draw sum * amplitude
        OP_KDT   = 3'd2,  // dt^2 * inverse_mass, exact
        OP_ACC   = 3'd3,  // force * dt^2/m
        OP_SCALE = 3'd4,  // lambda * displacement
        OP_HDG   = 3'd5,  // half_dt_gamma * previous
        OP_LANG  = 3'd6   // langevin factor * sum
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic seed_wr;
        logic mem_rd;
        logic seed_ld;
        logic lcg_step;
        logic state_wr;
        logic op_set;
        logic mul_step;
        logic round;
        logic wb;
        logic out_load;
        op_t  op;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_load;
        logic langevin;
        logic scaled;
        logic lcg_last;
        logic mul_last;
    } dp_stat_t;

    // Saturate to signed 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/verlet_thermostat_position_step_top.sv */
// Verlet position step with optional Langevin noise, one coordinate per item.
// Instantiates vtps_ctrl and vtps_datapath; depends on vtps_pkg.
//
// Usage:
//   s_valid/s_ready/s_data carries one coordinate step or one seed load.
//   m_valid/m_ready/m_data carries the new position and the force used.
//   cfg_we/cfg_index/cfg_wdata writes a register; write only
//   while the block is idle.
// Sequence per item (one item in flight at a time):
//   seed load: no result; the seed is written, then s_ready returns.
//   hold, unused mode, zero dt^2 or frozen atom: no multiply, straight out.
//   scaled Verlet: three multiplies (dt^2/m, acceleration, lambda scale).
//   Langevin: DRAWS_PER_SAMPLE LCG draws, then six multiplies.
// Each multiply runs four 32x32 partial products on one shared multiplier,
// then a rounding step and a write-back step; the LCG does one draw a cycle.
// A finished result sits in the output register; the next item is accepted
// meanwhile and only waits at its end if that register is still full.
// Reset (aresetn low, synchronous) restores register defaults and empties
// the output; the random state store is not cleared and must be seeded.
`default_nettype none

module verlet_thermostat_position_step_top #(
    parameter int MAX_ATOMS        = vtps_pkg::MAX_ATOMS_DEF,
    parameter int DRAWS_PER_SAMPLE = vtps_pkg::DRAWS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vtps_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vtps_pkg::out_item_t      m_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [47:0]         cfg_wdata
);

    vtps_pkg::ctl_cmd_t ctl;
    vtps_pkg::dp_stat_t stat;

    vtps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    vtps_datapath #(
        .MAX_ATOMS        (MAX_ATOMS),
        .DRAWS_PER_SAMPLE (DRAWS_PER_SAMPLE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .ctl       (ctl),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/vtps_datapath.sv */
// Datapath: config registers, per-atom random state memory, LCG,
// shared 32x32 multiply-accumulate with rounding. Depends on vtps_pkg.
`default_nettype none

module vtps_datapath #(
    parameter int MAX_ATOMS        = vtps_pkg::MAX_ATOMS_DEF,
    parameter int DRAWS_PER_SAMPLE = vtps_pkg::DRAWS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_wdata,
    input  wire vtps_pkg::in_item_t s_data,
    input  wire vtps_pkg::ctl_cmd_t ctl,
    output vtps_pkg::dp_stat_t      stat,
    output vtps_pkg::out_item_t     m_data
);

    localparam int AW    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW    = (DRAWS_PER_SAMPLE > 1) ? $clog2(DRAWS_PER_SAMPLE) : 1;
    localparam int SUM_W = 48 + $clog2(DRAWS_PER_SAMPLE + 1);
    localparam logic [CW-1:0] LCG_LAST = CW'(DRAWS_PER_SAMPLE - 1);
    localparam logic [63:0] DRAW_BIAS  = 64'(DRAWS_PER_SAMPLE) << 47;

    // Fold atom index into the store depth
    function automatic logic [AW-1:0] slot_of(input logic [9:0] idx);
        logic [16:0] v;
        v = 17'(idx);
        for (int k = 9; k >= 0; k--) begin
            if ((MAX_ATOMS << k) <= 1023 && v >= 17'(MAX_ATOMS << k)) begin
                v = v - 17'(MAX_ATOMS << k);
            end
        end
        return v[AW-1:0];
    endfunction

    // Config registers
    logic [1:0]  mode_reg;
    logic [31:0] lambda_reg, dt2_reg, lfac_reg, hdg_reg;
    logic [47:0] noise_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= vtps_pkg::MODE_HOLD;
            lambda_reg <= vtps_pkg::LAMBDA_RST;
            dt2_reg    <= '0;
            lfac_reg   <= vtps_pkg::LFACTOR_RST;
            hdg_reg    <= '0;
            noise_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vtps_pkg::CFG_STEP_MODE:  mode_reg   <= cfg_wdata[1:0];
                vtps_pkg::CFG_LAMBDA:     lambda_reg <= cfg_wdata[31:0];
                vtps_pkg::CFG_DT_SQUARED: dt2_reg    <= cfg_wdata[31:0];
                vtps_pkg::CFG_LFACTOR:    lfac_reg   <= cfg_wdata[31:0];
                vtps_pkg::CFG_HALF_DTG:   hdg_reg    <= cfg_wdata[31:0];
                vtps_pkg::CFG_NOISE_AMP:  noise_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Working registers
    vtps_pkg::in_item_t  item_reg;
    vtps_pkg::out_item_t out_reg;
    logic [47:0]         rd_q_reg, st_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [CW-1:0]       lcnt_reg;
    logic [63:0]         opa_reg, opb_reg, mag_reg, am_reg, kdt_reg;
    logic                neg_reg;
    logic [1:0]          mcnt_reg;
    logic [127:0]        prod_reg;
    logic signed [47:0]  force_reg, xn_reg;
    logic signed [63:0]  acc_reg, h_reg;
    logic [47:0]         rng_mem [MAX_ATOMS];

    logic [AW-1:0] slot;
    assign slot = slot_of(item_reg.atom_index);

    // One LCG step, low 48 bits of the product only
    logic [63:0] lcg_p0;
    logic [15:0] lcg_c1, lcg_c2;
    logic [47:0] st_next;
    assign lcg_p0  = 64'(st_reg[31:0]) * 64'(vtps_pkg::LCG_MUL[31:0]);
    assign lcg_c1  = 16'(st_reg[15:0] * {13'd0, vtps_pkg::LCG_MUL[34:32]});
    assign lcg_c2  = 16'(st_reg[47:32] * vtps_pkg::LCG_MUL[15:0]);
    assign st_next = lcg_p0[47:0] + {lcg_c1 + lcg_c2, 32'd0} + vtps_pkg::LCG_ADD;

    // Signed views
    logic signed [63:0] x0, xm, fx, rdf, res;
    assign x0  = $signed({{16{item_reg.position_now[47]}}, item_reg.position_now});
    assign xm  = $signed({{16{item_reg.position_before[47]}}, item_reg.position_before});
    assign fx  = $signed({{16{force_reg[47]}}, force_reg});
    assign rdf = $signed(64'(sum_reg) - DRAW_BIAS);
    assign res = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

    // Operand select
    logic signed [63:0] op_v;
    logic [63:0]        op_b, op_mag;
    logic [6:0]         shamt;
    always_comb begin
        op_v  = '0;
        op_b  = '0;
        shamt = 7'd0;
        unique case (ctl.op)
            vtps_pkg::OP_AM: begin
                op_v = $signed(64'(noise_reg));  op_b = 64'(item_reg.sqrt_mass);
                shamt = 7'd20;
            end
            vtps_pkg::OP_NOISE: begin
                op_v = rdf;  op_b = am_reg;  shamt = 7'd48;
            end
            vtps_pkg::OP_KDT: begin
                op_v = $signed(64'(dt2_reg));  op_b = 64'(item_reg.inverse_mass);
                shamt = 7'd0;
            end
            vtps_pkg::OP_ACC: begin
                op_v = fx;  op_b = kdt_reg;  shamt = 7'd56;
            end
            vtps_pkg::OP_SCALE: begin
                op_v = x0 - xm + acc_reg;  op_b = 64'(lambda_reg);  shamt = 7'd30;
            end
            vtps_pkg::OP_HDG: begin
                op_v = xm;  op_b = 64'(hdg_reg);  shamt = 7'd32;
            end
            vtps_pkg::OP_LANG: begin
                op_v = (x0 <<< 1) - xm + acc_reg + h_reg;  op_b = 64'(lfac_reg);
                shamt = 7'd31;
            end
            default: ;
        endcase
        op_mag = op_v[63] ? 64'(-op_v) : 64'(op_v);
    end

    // Partial product step
    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [6:0]   pp_sh;
    logic [127:0] prod_next;
    assign a_half    = mcnt_reg[1] ? opa_reg[63:32] : opa_reg[31:0];
    assign b_half    = mcnt_reg[0] ? opb_reg[63:32] : opb_reg[31:0];
    assign pp        = 64'(a_half) * 64'(b_half);
    assign pp_sh     = {mcnt_reg[1] & mcnt_reg[0], mcnt_reg[1] ^ mcnt_reg[0], 5'd0};
    assign prod_next = prod_reg + (128'(pp) << pp_sh);

    // Round to nearest, ties away, then cap
    logic [128:0] half, rsum, q;
    logic         cap;
    logic [63:0]  mag_next;
    always_comb begin
        half     = (shamt == 7'd0) ? '0 : (129'd1 << (shamt - 7'd1));
        rsum     = {1'b0, prod_reg} + half;
        q        = rsum >> shamt;
        cap      = (shamt != 7'd0) && (q > 129'(vtps_pkg::PROD_CAP));
        mag_next = cap ? vtps_pkg::PROD_CAP : q[63:0];
    end

    // Counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcnt_reg <= '0;
            mcnt_reg <= '0;
        end else begin
            if (ctl.seed_ld) lcnt_reg <= '0;
            else if (ctl.lcg_step) lcnt_reg <= lcnt_reg + CW'(1);
            if (ctl.op_set) mcnt_reg <= '0;
            else if (ctl.mul_step) mcnt_reg <= mcnt_reg + 2'd1;
        end
    end

    // Random state store, one port
    always_ff @(posedge aclk) begin
        if (ctl.seed_wr) begin
            rng_mem[slot] <= item_reg.seed_value;
        end else if (ctl.state_wr) begin
            rng_mem[slot] <= st_reg;
        end
        if (ctl.mem_rd) rd_q_reg <= rng_mem[slot];
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            item_reg  <= s_data;
            force_reg <= s_data.force_in;
            xn_reg    <= s_data.position_now;
        end
        if (ctl.seed_ld) begin
            st_reg  <= rd_q_reg;
            sum_reg <= '0;
        end else if (ctl.lcg_step) begin
            st_reg  <= st_next;
            sum_reg <= sum_reg + SUM_W'(st_next);
        end
        if (ctl.op_set) begin
            opa_reg  <= op_mag;
            opb_reg  <= op_b;
            neg_reg  <= op_v[63];
            prod_reg <= '0;
        end else if (ctl.mul_step) begin
            prod_reg <= prod_next;
        end
        if (ctl.round) mag_reg <= mag_next;
        if (ctl.wb) begin
            case (ctl.op)
                vtps_pkg::OP_AM:    am_reg    <= mag_reg;
                vtps_pkg::OP_NOISE: force_reg <= vtps_pkg::sat48(fx + res);
                vtps_pkg::OP_KDT:   kdt_reg   <= mag_reg;
                vtps_pkg::OP_ACC:   acc_reg   <= res;
                vtps_pkg::OP_SCALE: xn_reg    <= vtps_pkg::sat48(x0 + res);
                vtps_pkg::OP_HDG:   h_reg     <= res;
                vtps_pkg::OP_LANG:  xn_reg    <= vtps_pkg::sat48(res);
                default: ;
            endcase
        end
        if (ctl.out_load) begin
            out_reg.new_position <= xn_reg;
            out_reg.force_out    <= force_reg;
        end
    end

    // Status
    logic active;
    assign active        = item_reg.movable && (dt2_reg != 32'd0);
    assign stat.is_load  = (item_reg.cmd == vtps_pkg::CMD_LOAD);
    assign stat.langevin = active && (mode_reg == vtps_pkg::MODE_LANGEVIN);
    assign stat.scaled   = active && (mode_reg == vtps_pkg::MODE_SCALED);
    assign stat.lcg_last = (lcnt_reg == LCG_LAST);
    assign stat.mul_last = (mcnt_reg == 2'd3);
    assign m_data        = out_reg;

endmodule

`default_nettype wire

/* rtl/core/vtps_ctrl.sv */
// Controller: sequences load, LCG draws and the multiply chain,
// owns the result valid flag. Depends on vtps_pkg.
`default_nettype none

module vtps_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire vtps_pkg::dp_stat_t stat,
    output vtps_pkg::ctl_cmd_t      ctl
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECIDE = 12'b0000_0000_0010,
        S_LOAD   = 12'b0000_0000_0100,
        S_READ   = 12'b0000_0000_1000,
        S_SEED   = 12'b0000_0001_0000,
        S_LCG    = 12'b0000_0010_0000,
        S_WRITE  = 12'b0000_0100_0000,
        S_OPSET  = 12'b0000_1000_0000,
        S_MUL    = 12'b0001_0000_0000,
        S_ROUND  = 12'b0010_0000_0000,
        S_WB     = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    vtps_pkg::op_t   op_reg, op_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;
        ctl          = '0;
        ctl.op       = op_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.is_load) begin
                    state_next = S_LOAD;
                end else if (stat.langevin) begin
                    state_next = S_READ;
                end else if (stat.scaled) begin
                    op_next    = vtps_pkg::OP_KDT;
                    state_next = S_OPSET;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_LOAD: begin
                ctl.seed_wr = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ: begin
                ctl.mem_rd = 1'b1;
                state_next = S_SEED;
            end
            S_SEED: begin
                ctl.seed_ld = 1'b1;
                state_next  = S_LCG;
            end
            S_LCG: begin
                ctl.lcg_step = 1'b1;
                if (stat.lcg_last) state_next = S_WRITE;
            end
            S_WRITE: begin
                ctl.state_wr = 1'b1;
                op_next      = vtps_pkg::OP_AM;
                state_next   = S_OPSET;
            end
            S_OPSET: begin
                ctl.op_set = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                ctl.mul_step = 1'b1;
                if (stat.mul_last) state_next = S_ROUND;
            end
            S_ROUND: begin
                ctl.round  = 1'b1;
                state_next = S_WB;
            end
            S_WB: begin
                ctl.wb     = 1'b1;
                state_next = S_OPSET;
                case (op_reg)
                    vtps_pkg::OP_AM:    op_next = vtps_pkg::OP_NOISE;
                    vtps_pkg::OP_NOISE: op_next = vtps_pkg::OP_KDT;
                    vtps_pkg::OP_KDT:   op_next = vtps_pkg::OP_ACC;
                    vtps_pkg::OP_ACC:
                        op_next = stat.langevin ? vtps_pkg::OP_HDG : vtps_pkg::OP_SCALE;
                    vtps_pkg::OP_HDG:   op_next = vtps_pkg::OP_LANG;
                    default:            state_next = S_OUT;
                endcase
            end
            S_OUT: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= vtps_pkg::OP_AM;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/vtps_checker.sv */
// Port-level checker for the Verlet position step block, bound to the top.
// Depends on vtps_pkg and the assertion macro header.
`default_nettype none
`include "verlet_thermostat_position_step_top_defines.svh"

module vtps_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire vtps_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire vtps_pkg::out_item_t m_data
);

    // Stalled result holds
    `VTPS_ASSERT_NEXT(a_out_hold, aclk, !aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "result changed under stall")

    // One item at a time: no transfer right after a transfer
    `VTPS_ASSERT_NEXT(a_one_item, aclk, !aresetn, s_valid && s_ready,
        !s_ready, "input taken twice in a row")

    // Seed load frees the input again once the seed is written
    `VTPS_ASSERT_IMPLY(a_load_ready, aclk, !aresetn,
        s_valid && s_ready && s_data.cmd == vtps_pkg::CMD_LOAD,
        ##3 s_ready, "seed load did not finish")

    // Reset empties the output
    `VTPS_ASSERT_NEXT(a_reset_empty, aclk, 1'b0, !aresetn,
        !m_valid, "result valid after reset")

endmodule

bind verlet_thermostat_position_step_top vtps_checker u_vtps_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for verlet_thermostat_position_step_top.
// Holds its own position-step predictor; depends on vtps_pkg and the RTL top.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    vtps_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    vtps_pkg::out_item_t m_data;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [47:0]         cfg_wdata = '0;

    verlet_thermostat_position_step_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Predictor state
    logic [1:0]  pm_mode;
    logic [31:0] pm_lambda, pm_dt2, pm_lfac, pm_hdg;
    logic [47:0] pm_amp;
    logic [47:0] seed_mem [0:1023];
    bit          seeded [0:1023];

    vtps_pkg::in_item_t  pending_items[$];
    vtps_pkg::out_item_t expected_steps[$];
    int                  fail_count = 0;
    int                  steps_seen = 0;
    int                  src_idle_pct = 0;
    int                  dst_stall_pct = 0;

    // Append one item to the driver queue
    task automatic enqueue_item(input vtps_pkg::in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // Rounded, capped product of magnitudes: round(a*b / 2^s), ties up
    function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        logic [127:0] q;
        p = 128'(a) * 128'(b);
        p = p + (128'd1 << (s - 1));
        q = p >> s;
        if (q > 128'(vtps_pkg::PROD_CAP)) return vtps_pkg::PROD_CAP;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] round_smul(input logic signed [63:0] v,
                                                      input logic [63:0] u, input int s);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r = round_mul(mag, u, s);
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return v;
    endfunction

    // Advance the predictor with one accepted item
    task automatic predict_step(input vtps_pkg::in_item_t it);
        logic signed [63:0]  x0, xm, f, xn, rdf, acc, d, h, sm;
        logic [63:0]         sum, am;
        logic [47:0]         st;
        logic                active;
        vtps_pkg::out_item_t r;
        x0 = 64'(it.position_now);
        xm = 64'(it.position_before);
        f  = 64'(it.force_in);
        xn = x0;
        active = it.movable && (pm_dt2 != 0);
        if (it.cmd == vtps_pkg::CMD_LOAD) begin
            seed_mem[it.atom_index] = it.seed_value;
            return;
        end
        if (active && pm_mode == vtps_pkg::MODE_LANGEVIN) begin
            st = seed_mem[it.atom_index];
            sum = 0;
            for (int k = 0; k < 12; k++) begin
                st = 48'(64'(vtps_pkg::LCG_MUL) * 64'(st) + 64'(vtps_pkg::LCG_ADD));
                sum += 64'(st);
            end
            seed_mem[it.atom_index] = st;
            rdf = $signed(sum) - $signed(64'd12 << 47);
            am = round_mul(64'(pm_amp), 64'(it.sqrt_mass), 20);
            f = clamp48(f + round_smul(rdf, am, 48));
        end
        if (active && (pm_mode == vtps_pkg::MODE_SCALED ||
                       pm_mode == vtps_pkg::MODE_LANGEVIN)) begin
            acc = round_smul(f, 64'(pm_dt2) * 64'(it.inverse_mass), 56);
            if (pm_mode == vtps_pkg::MODE_SCALED) begin
                d = x0 - xm + acc;
                xn = clamp48(x0 + round_smul(d, 64'(pm_lambda), 30));
            end else begin
                h = round_smul(xm, 64'(pm_hdg), 32);
                sm = 2 * x0 - xm + acc + h;
                xn = clamp48(round_smul(sm, 64'(pm_lfac), 31));
            end
        end
        r.new_position = xn[47:0];
        r.force_out = f[47:0];
        expected_steps.insert(expected_steps.size(), r);
    endtask

    // Driver: presents queued items, accepted items go to the predictor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_step(s_data);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= dst_stall_pct);
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        vtps_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            steps_seen++;
            if (expected_steps.size() == 0) begin
                $error("unexpected result transfer %h", m_data);
                fail_count++;
            end else begin
                e = expected_steps.pop_front();
                if (m_data.new_position !== e.new_position) begin
                    $error("new_position exp %h got %h", e.new_position, m_data.new_position);
                    fail_count++;
                end
                if (m_data.force_out !== e.force_out) begin
                    $error("force_out exp %h got %h", e.force_out, m_data.force_out);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            vtps_pkg::CFG_STEP_MODE:  pm_mode = val[1:0];
            vtps_pkg::CFG_LAMBDA:     pm_lambda = val[31:0];
            vtps_pkg::CFG_DT_SQUARED: pm_dt2 = val[31:0];
            vtps_pkg::CFG_LFACTOR:    pm_lfac = val[31:0];
            vtps_pkg::CFG_HALF_DTG:   pm_hdg = val[31:0];
            vtps_pkg::CFG_NOISE_AMP:  pm_amp = val;
            default: ;
        endcase
    endtask

    // Wait for the block to drain, then allow the load tail
    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_steps.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    function automatic logic [47:0] rnd48();
        case ($urandom_range(5))
            0: return 48'h7FFF_FFFF_FFFF;
            1: return 48'h8000_0000_0000;
            2: return 48'(int'($urandom_range(2000)) - 1000);
            default: return 48'({$urandom(), $urandom()});
        endcase
    endfunction

    // Random coordinate step on an atom that has a seed
    function automatic vtps_pkg::in_item_t rand_step();
        vtps_pkg::in_item_t it;
        int a;
        it = '0;
        a = $urandom_range(7);
        while (!seeded[a]) a = $urandom_range(7);
        it.cmd = vtps_pkg::CMD_STEP;
        it.atom_index = 10'(a);
        it.axis = 2'($urandom_range(3));
        it.movable = ($urandom_range(9) != 0);
        it.position_now = rnd48();
        it.position_before = ($urandom_range(1)) ? it.position_now + 48'($urandom_range(4096))
                                                 : rnd48();
        it.force_in = rnd48();
        it.inverse_mass = $urandom();
        it.sqrt_mass = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom();
        it.seed_value = rnd48();
        return it;
    endfunction

    function automatic vtps_pkg::in_item_t seed_item(input logic [9:0] a,
                                                     input logic [47:0] v);
        vtps_pkg::in_item_t it;
        it = '0;
        it.cmd = vtps_pkg::CMD_LOAD;
        it.atom_index = a;
        it.seed_value = v;
        it.position_now = rnd48();
        it.force_in = rnd48();
        it.inverse_mass = $urandom();
        it.sqrt_mass = $urandom();
        return it;
    endfunction

    initial begin
        vtps_pkg::in_item_t it;
        pm_mode = vtps_pkg::MODE_HOLD; pm_lambda = vtps_pkg::LAMBDA_RST; pm_dt2 = 0;
        pm_lfac = vtps_pkg::LFACTOR_RST; pm_hdg = 0; pm_amp = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: seeds including the highest index and an all-ones state
        enqueue_item(seed_item(10'd0, 48'h0));
        enqueue_item(seed_item(10'd1023, 48'hFFFF_FFFF_FFFF));
        for (int a = 1; a < 8; a++) enqueue_item(seed_item(10'(a), rnd48()));
        seeded[0] = 1; seeded[1023] = 1;
        for (int a = 1; a < 8; a++) seeded[a] = 1;
        // Reset settings: hold with zero time step
        it = rand_step(); enqueue_item(it);
        drain();
        write_reg(vtps_pkg::CFG_STEP_MODE, 48'(vtps_pkg::MODE_LANGEVIN));
        write_reg(vtps_pkg::CFG_DT_SQUARED, 48'h0);
        it = rand_step(); it.movable = 1; enqueue_item(it);
        drain();
        // Extreme registers, Langevin on the top index with field extremes
        write_reg(vtps_pkg::CFG_DT_SQUARED, 48'hFFFF_FFFF);
        write_reg(vtps_pkg::CFG_NOISE_AMP, 48'hFFFF_FFFF_FFFF);
        write_reg(vtps_pkg::CFG_LFACTOR, 48'hFFFF_FFFF);
        write_reg(vtps_pkg::CFG_HALF_DTG, 48'hFFFF_FFFF);
        write_reg(vtps_pkg::CFG_LAMBDA, 48'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) begin
            it = rand_step();
            it.atom_index = 10'd1023; it.movable = 1; it.axis = 2'(k);
            it.position_now = k[0] ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            it.position_before = k[1] ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
            it.force_in = k[0] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            it.inverse_mass = 32'hFFFF_FFFF; it.sqrt_mass = 32'hFFFF_FFFF;
            enqueue_item(it);
        end
        it = rand_step(); it.movable = 0; enqueue_item(it);
        drain();
        // Scaled, then unused mode 3
        write_reg(vtps_pkg::CFG_STEP_MODE, 48'(vtps_pkg::MODE_SCALED));
        write_reg(vtps_pkg::CFG_LAMBDA, 48'h0);
        for (int k = 0; k < 3; k++) enqueue_item(rand_step());
        drain();
        write_reg(vtps_pkg::CFG_STEP_MODE, 48'd3);
        for (int k = 0; k < 3; k++) enqueue_item(rand_step());
        drain();

        // Random phases over settings and idling patterns
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin src_idle_pct = 0;  dst_stall_pct = 0;  end
                1: begin src_idle_pct = 53; dst_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  dst_stall_pct = 53; end
                default: begin src_idle_pct = 37; dst_stall_pct = 37; end
            endcase
            write_reg(vtps_pkg::CFG_STEP_MODE,
                      48'((ph % 5 == 4) ? vtps_pkg::MODE_HOLD :
                          (ph % 2) ? vtps_pkg::MODE_SCALED : vtps_pkg::MODE_LANGEVIN));
            write_reg(vtps_pkg::CFG_LAMBDA, (ph == 3) ? 48'hFFFF_FFFF : 48'($urandom()));
            write_reg(vtps_pkg::CFG_DT_SQUARED, (ph == 5) ? 48'h0 :
                      (ph % 3 == 0) ? 48'($urandom_range(65536)) : 48'($urandom()));
            write_reg(vtps_pkg::CFG_LFACTOR, (ph == 6) ? 48'h0 : 48'($urandom()));
            write_reg(vtps_pkg::CFG_HALF_DTG, 48'($urandom()));
            write_reg(vtps_pkg::CFG_NOISE_AMP, (ph == 7) ? 48'h0 : rnd48());
            for (int k = 0; k < 96; k++) begin
                if ($urandom_range(19) == 0)
                    enqueue_item(seed_item(10'($urandom_range(7)), rnd48()));
                else
                    enqueue_item(rand_step());
            end
            drain();
        end
        src_idle_pct = 0; dst_stall_pct = 0;
        drain();

        $display("Ran directed extremes and %0d result transfers over hold, scaled,", steps_seen);
        $display("Langevin and unused modes with seeded atoms and mixed idling.");
        if (fail_count == 0 && expected_steps.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end
endmodule
